// ----- src/hrsp_pkg.sv -----
// Shared types and constants of the HEX record stream parser.
// Used by the front queue, the parser core, the result queue and the top level.
`default_nettype none

package hrsp_pkg;

  localparam int unsigned LINE_NUMBER_BITS = 24;
  localparam int unsigned POS_BITS         = 10;
  localparam int unsigned CFG_INDEX_BITS   = 1;

  typedef logic [LINE_NUMBER_BITS-1:0] line_t;
  typedef logic [POS_BITS-1:0]         pos_t;

  localparam line_t     LINE_MAX       = '1;
  localparam pos_t      POS_MAX        = 10'd1023;
  localparam pos_t      POS_COUNT      = 10'd2;
  localparam pos_t      POS_ADDR_HI    = 10'd4;
  localparam pos_t      POS_ADDR_LO    = 10'd6;
  localparam pos_t      POS_START      = 10'd7;
  localparam pos_t      POS_KIND       = 10'd8;
  localparam pos_t      POS_EXT_FIRST  = 10'd9;
  localparam pos_t      POS_EXT_LAST   = 10'd12;
  localparam pos_t      POS_DATA_FIRST = 10'd10;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;

  // record types
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_SEG   = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_ADDR = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ADDR = 1'b1;

  typedef enum logic {
    RES_DATA   = 1'b0,
    RES_STATUS = 1'b1
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_LENGTH    = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_TYPE      = 3'd4
  } status_e;

  // classified input item
  typedef struct packed {
    logic       new_file;
    logic       is_colon;
    logic       digit_ok;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    line_t       line_number;
    status_e     status;
    logic        range_low;
    logic        range_high;
    logic [7:0]  record_kind;
  } result_t;

endpackage

`default_nettype wire

// ----- src/hrsp_front.sv -----
// Front end: classifies each incoming character (hex digit, start code) and
// holds it in a two-entry queue toward the parser core. Depends on hrsp_pkg.
`default_nettype none

module hrsp_front
  import hrsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       line_end_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  wire logic       cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in          = '0;
    cmd_in.new_file = req_type_i;
    cmd_in.is_colon = (char_code_i == CHAR_COLON);
    cmd_in.last     = line_end_i;
    cmd_in.digit_ok = 1'b1;
    if (char_code_i inside {[8'h30:8'h39]}) begin
      cmd_in.digit = char_code_i[3:0];
    end else if ((char_code_i inside {[8'h41:8'h46]}) ||
                 (char_code_i inside {[8'h61:8'h66]})) begin
      cmd_in.digit = char_code_i[3:0] + 4'd9;
    end else begin
      cmd_in.digit    = 4'd0;
      cmd_in.digit_ok = 1'b0;
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = cmd_pop_i & cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push & ~do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop & ~do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_in;
  end

endmodule

`default_nettype wire

// ----- src/hrsp_back.sv -----
// Parser core: per-character record state, extended base address and configured
// range checks, one classified item per cycle unless res_full_i is set. Depends on hrsp_pkg.
`default_nettype none

module hrsp_back
  import hrsp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [31:0]               cfg_wdata_i,
  input  wire logic                      cmd_valid_i,
  input  wire cmd_t                      cmd_i,
  output logic                           cmd_pop_o,
  input  wire logic                      res_full_i,
  output logic                           res_valid_o,
  output result_t                        res_o
);

  logic [31:0] min_addr_q, max_addr_q;
  logic [31:0] base_q, base_d;
  line_t       line_q, line_d;
  pos_t        pos_q, pos_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] rec_q, rec_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  sum_q, sum_d;
  logic [4:0]  hn_q, hn_d;
  logic [16:0] ext_q, ext_d;
  logic        start_ok_q, start_ok_d;
  logic [31:0] start_q, start_d;
  logic [31:0] end_q, end_d;
  logic [31:0] baddr_q, baddr_d;

  logic        go, in_pair;
  logic [7:0]  pair_byte;
  logic [8:0]  byte_idx;
  pos_t        want_pos;
  logic [15:0] ext_val;

  assign go        = cmd_valid_i & ~res_full_i;
  assign cmd_pop_o = go;
  assign in_pair   = (pos_q != '0) && (pos_q != POS_MAX);
  assign pair_byte = (hn_q[4] & cmd_i.digit_ok) ? {hn_q[3:0], cmd_i.digit} : 8'd0;
  assign byte_idx  = 9'((pos_q - POS_DATA_FIRST) >> 1);
  assign want_pos  = {1'b0, count_d, 1'b0} + POS_DATA_FIRST;
  assign ext_val   = ext_d[16] ? ext_d[15:0] : 16'd0;

  always_comb begin
    base_d      = base_q;
    line_d      = line_q;
    pos_d       = pos_q;
    count_d     = count_q;
    rec_d       = rec_q;
    kind_d      = kind_q;
    sum_d       = sum_q;
    hn_d        = hn_q;
    ext_d       = ext_q;
    start_ok_d  = start_ok_q;
    start_d     = start_q;
    end_d       = end_q;
    baddr_d     = baddr_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (go) begin
      if (cmd_i.new_file || (pos_q == '0)) begin
        // drop any partial line
        pos_d      = '0;
        count_d    = '0;
        rec_d      = '0;
        kind_d     = '0;
        sum_d      = '0;
        hn_d       = '0;
        ext_d      = 17'h10000;
        start_ok_d = 1'b0;
      end

      if (cmd_i.new_file) begin
        base_d = '0;
        line_d = '0;
      end else begin
        if (pos_q == '0) begin
          if (line_q != LINE_MAX) line_d = line_q + 1'b1;
          start_ok_d = cmd_i.is_colon;
        end

        if (pos_q inside {[POS_EXT_FIRST:POS_EXT_LAST]}) begin
          ext_d = {ext_q[16] & cmd_i.digit_ok, ext_q[11:0], cmd_i.digit};
        end

        if (pos_q == POS_START) begin
          start_d = base_q + {16'd0, rec_q};
          baddr_d = start_d;
        end

        if (in_pair && pos_q[0]) begin
          hn_d = {cmd_i.digit_ok, cmd_i.digit};
        end else if (in_pair) begin
          sum_d = sum_q + pair_byte;
          case (pos_q)
            POS_COUNT:   count_d = pair_byte;
            POS_ADDR_HI: rec_d[15:8] = pair_byte;
            POS_ADDR_LO: rec_d[7:0] = pair_byte;
            POS_KIND: begin
              kind_d = pair_byte;
              end_d  = start_q + {24'd0, count_q};
            end
            default: begin
              if (pos_q >= POS_DATA_FIRST) begin
                baddr_d = baddr_q + 32'd1;
                if ((byte_idx < {1'b0, count_q}) && (kind_q == REC_DATA) &&
                    start_ok_q && !cmd_i.last) begin
                  res_valid_o        = 1'b1;
                  res_o.kind         = RES_DATA;
                  res_o.byte_address = baddr_q;
                  res_o.data_byte    = pair_byte;
                end
              end
            end
          endcase
        end

        if (cmd_i.last) begin
          res_valid_o = 1'b1;
          res_o.kind  = RES_STATUS;
          pos_d       = '0;
          if (!start_ok_d) begin
            res_o.status = ST_BAD_START;
          end else if (pos_q != want_pos) begin
            res_o.status = ST_LENGTH;
          end else if (sum_d != 8'd0) begin
            res_o.status = ST_CHECKSUM;
          end else begin
            res_o.status = ST_OK;
            case (kind_d)
              REC_DATA: begin
                res_o.range_low  = (min_addr_q > start_q);
                res_o.range_high = (max_addr_q < end_q);
              end
              REC_EOF, REC_START_SEG, REC_START_LIN: ;
              REC_EXT_SEG: base_d = {12'd0, ext_val, 4'd0};
              REC_EXT_LIN: base_d = {ext_val, 16'd0};
              default:     res_o.status = ST_TYPE;
            endcase
          end
        end else if (pos_q != POS_MAX) begin
          pos_d = pos_q + 1'b1;
        end

        res_o.line_number = line_d;
        res_o.record_kind = kind_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_addr_q <= '0;
      max_addr_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_ADDR: min_addr_q <= cfg_wdata_i;
        CFG_MAX_ADDR: max_addr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      line_q     <= '0;
      pos_q      <= '0;
      count_q    <= '0;
      rec_q      <= '0;
      kind_q     <= '0;
      sum_q      <= '0;
      hn_q       <= '0;
      ext_q      <= 17'h10000;
      start_ok_q <= 1'b0;
    end else begin
      base_q     <= base_d;
      line_q     <= line_d;
      pos_q      <= pos_d;
      count_q    <= count_d;
      rec_q      <= rec_d;
      kind_q     <= kind_d;
      sum_q      <= sum_d;
      hn_q       <= hn_d;
      ext_q      <= ext_d;
      start_ok_q <= start_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    baddr_q <= baddr_d;
  end

endmodule

`default_nettype wire

// ----- src/hrsp_outq.sv -----
// Result queue: two-entry queue that holds finished results until the
// consumer pops them. Depends on hrsp_pkg.
`default_nettype none

module hrsp_outq
  import hrsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         empty_o,
  output result_t      head_o,
  input  wire logic    pop_i
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push & ~do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop & ~do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ----- src/hex_record_stream_parser_top.sv -----
// HEX record stream parser, one character per item. The block sustains one
// character per clock unless a queue is full: the parser core updates its line state
// once per character, between a two-entry input queue and a two-entry result queue,
// so a character is registered in the input queue and its result in the result queue
// ahead of the result ports. Each data byte of a type-00 record comes out as a
// provisional result, and the last character of a line yields one status result;
// discard the line's bytes when the status is not ok. There is no clearing pass
// after reset. Write min_address (index 0) and max_address (index 1) only while idle.
`default_nettype none

module hex_record_stream_parser_top
  import hrsp_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire logic [31:0]                 cfg_wdata_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        req_type_i,
  input  wire logic [7:0]                  char_code_i,
  input  wire logic                        line_end_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             result_kind_o,
  output logic [31:0]                      byte_address_o,
  output logic [7:0]                       data_byte_o,
  output logic [LINE_NUMBER_BITS-1:0]      line_number_o,
  output logic [2:0]                       line_status_o,
  output logic                             range_low_o,
  output logic                             range_high_o,
  output logic [7:0]                       record_kind_o
);

  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  result_t res, head;
  logic    res_valid, res_full;

  hrsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .line_end_i  (line_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  hrsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrsp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .head_o  (head),
    .pop_i   (pop)
  );

  assign result_kind_o  = head.kind;
  assign byte_address_o = head.byte_address;
  assign data_byte_o    = head.data_byte;
  assign line_number_o  = head.line_number;
  assign line_status_o  = head.status;
  assign range_low_o    = head.range_low;
  assign range_high_o   = head.range_high;
  assign record_kind_o  = head.record_kind;

endmodule

`default_nettype wire

// ----- src/hrsp_checker.sv -----
// Port-level checks of the HEX record stream parser, bound to the top level.
// Depends on hrsp_pkg and hex_record_stream_parser_top.
`default_nettype none

module hrsp_checker
  import hrsp_pkg::*;
(
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic                        result_kind_o,
  input wire logic [31:0]                 byte_address_o,
  input wire logic [7:0]                  data_byte_o,
  input wire logic [LINE_NUMBER_BITS-1:0] line_number_o,
  input wire logic [2:0]                  line_status_o,
  input wire logic                        range_low_o,
  input wire logic                        range_high_o,
  input wire logic [7:0]                  record_kind_o
);

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(byte_address_o) && $stable(data_byte_o) &&
                          $stable(line_status_o) && $stable(result_kind_o)))
    else $error("waiting result changed before transfer");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == RES_STATUS) |-> (byte_address_o == '0 && data_byte_o == '0))
    else $error("status result carries address or data");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == RES_DATA) |->
      (line_status_o == ST_OK && !range_low_o && !range_high_o &&
       record_kind_o == REC_DATA && line_number_o != '0))
    else $error("data result with status fields set");

  a_range_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (range_low_o || range_high_o)) |->
      (result_kind_o == RES_STATUS && line_status_o == ST_OK && record_kind_o == REC_DATA))
    else $error("range flag outside a good data record status");

endmodule

bind hex_record_stream_parser_top hrsp_checker u_checker (.*);

`default_nettype wire

// ----- dv/hex_record_stream_parser_top_tb.sv -----
// Self-checking testbench for the HEX record stream parser top level.
// Feeds directed and random HEX lines, predicts every data byte and line status
// in a scoreboard class. Depends on hrsp_pkg and hex_record_stream_parser_top.
`default_nettype none

module hex_record_stream_parser_top_tb;
  import hrsp_pkg::*;

  typedef enum int {
    FL_NONE,
    FL_START,
    FL_SHORT,
    FL_LONG,
    FL_SUM,
    FL_DIGIT,
    FL_CUT
  } flaw_e;

  // characters just outside the hex ranges, plus a few far away
  localparam logic [7:0] NON_HEX [10] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60,
                                          8'h67, 8'h00, 8'hFF, 8'h20, 8'hB0};

  class hex_parse_board;
    logic [31:0] min_addr, max_addr, base_addr;
    line_t       line_cnt;
    pos_t        pos;
    logic [7:0]  count, kind, sum;
    logic [15:0] rec_addr;
    logic [4:0]  hi_nib;
    logic [16:0] ext_val;
    bit          start_seen;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      min_addr  = '0;
      max_addr  = '1;
      base_addr = '0;
      line_cnt  = '0;
      errors    = 0;
      clear_line();
    endfunction

    function void clear_line();
      pos        = '0;
      count      = '0;
      rec_addr   = '0;
      kind       = '0;
      sum        = '0;
      hi_nib     = '0;
      ext_val    = 17'h10000;
      start_seen = 1'b0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
      if (idx == CFG_MIN_ADDR) min_addr = val;
      else if (idx == CFG_MAX_ADDR) max_addr = val;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void add_expected(res_kind_e k, logic [31:0] a, logic [7:0] db,
                               status_e st, bit lo, bit hi);
      result_t r;
      r.kind         = k;
      r.byte_address = a;
      r.data_byte    = db;
      r.line_number  = line_cnt;
      r.status       = st;
      r.range_low    = lo;
      r.range_high   = hi;
      r.record_kind  = kind;
      pending_results.push_back(r);
    endfunction

    // Advance the line state by one transferred character.
    function void parse_char(bit req, logic [7:0] c, bit last);
      pos_t        p;
      logic [3:0]  d;
      bit          ok;
      logic [7:0]  b;
      logic [31:0] idx, start_a, end_a;
      logic [15:0] ext;
      status_e     st;
      bit          lo, hi;
      p = pos;
      if (req) begin
        base_addr = '0;
        line_cnt  = '0;
        clear_line();
        return;
      end
      if (p == 0) begin
        clear_line();
        if (line_cnt != LINE_MAX) line_cnt++;
        start_seen = (c == CHAR_COLON);
      end
      ok = 1'b1;
      d  = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) d = c[3:0];
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) d = c[3:0] + 4'd9;
      else ok = 1'b0;

      if (p >= POS_EXT_FIRST && p <= POS_EXT_LAST)
        ext_val = {ext_val[16] & ok, ext_val[11:0], d};

      if (p >= 1 && p < POS_MAX) begin
        if (p[0]) begin
          hi_nib = {ok, d};
        end else begin
          b   = (hi_nib[4] && ok) ? {hi_nib[3:0], d} : 8'h00;
          sum = sum + b;
          case (p)
            POS_COUNT:   count = b;
            POS_ADDR_HI: rec_addr[15:8] = b;
            POS_ADDR_LO: rec_addr[7:0] = b;
            POS_KIND:    kind = b;
            default: begin
              idx = (32'(p) - 32'(POS_DATA_FIRST)) >> 1;
              if (idx < 32'(count) && kind == REC_DATA && start_seen && !last)
                add_expected(RES_DATA, base_addr + 32'(rec_addr) + idx, b, ST_OK, 0, 0);
            end
          endcase
        end
      end

      if (last) begin
        st = ST_OK;
        lo = 0;
        hi = 0;
        if (!start_seen) st = ST_BAD_START;
        else if (32'(p) != 2 * 32'(count) + 10) st = ST_LENGTH;
        else if (sum != 8'h00) st = ST_CHECKSUM;
        else begin
          ext = ext_val[16] ? ext_val[15:0] : 16'h0000;
          case (kind)
            REC_DATA: begin
              start_a = base_addr + 32'(rec_addr);
              end_a   = start_a + 32'(count);
              lo      = (min_addr > start_a);
              hi      = (max_addr < end_a);
            end
            REC_EOF, REC_START_SEG, REC_START_LIN: ;
            REC_EXT_SEG: base_addr = {12'h000, ext, 4'h0};
            REC_EXT_LIN: base_addr = {ext, 16'h0000};
            default:     st = ST_TYPE;
          endcase
        end
        add_expected(RES_STATUS, '0, '0, st, lo, hi);
        pos = '0;
      end else if (p < POS_MAX) begin
        pos = p + 1'b1;
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: kind %0d addr 0x%0h status %0d",
               got.kind, got.byte_address, got.status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("result_kind", want.kind, got.kind);
      cmp_field("byte_address", want.byte_address, got.byte_address);
      cmp_field("data_byte", want.data_byte, got.data_byte);
      cmp_field("line_number", want.line_number, got.line_number);
      cmp_field("line_status", want.status, got.status);
      cmp_field("range_low", want.range_low, got.range_low);
      cmp_field("range_high", want.range_high, got.range_high);
      cmp_field("record_kind", want.record_kind, got.record_kind);
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [31:0]               cfg_wdata_i;
  logic                      push;
  logic                      full;
  logic                      req_type_i;
  logic [7:0]                char_code_i;
  logic                      line_end_i;
  logic                      empty;
  logic                      pop;
  logic                      result_kind_o;
  logic [31:0]               byte_address_o;
  logic [7:0]                data_byte_o;
  logic [LINE_NUMBER_BITS-1:0] line_number_o;
  logic [2:0]                line_status_o;
  logic                      range_low_o;
  logic                      range_high_o;
  logic [7:0]                record_kind_o;

  hex_record_stream_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .char_code_i    (char_code_i),
    .line_end_i     (line_end_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .line_number_o  (line_number_o),
    .line_status_o  (line_status_o),
    .range_low_o    (range_low_o),
    .range_high_o   (range_high_o),
    .record_kind_o  (record_kind_o)
  );

  hex_parse_board board;
  bit             draining;
  bit             tx_steady;
  bit             rx_steady;
  int unsigned    items_sent;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10000000;
    $display("** hex_record_stream_parser_top: FAILED **");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 9) < 3) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one item and hold it until it transfers.
  task automatic send_item(bit req, logic [7:0] ch, bit last);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    req_type_i  <= req;
    char_code_i <= ch;
    line_end_i  <= last;
    do @(posedge clk_i); while (full);
    board.parse_char(req, ch, last);
    items_sent++;
  endtask

  task automatic send_line(ref logic [7:0] q[$], input bit with_end);
    for (int i = 0; i < q.size(); i++)
      send_item(1'b0, q[i], with_end && (i == q.size() - 1));
  endtask

  task automatic send_text(string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_line(q, 1'b1);
  endtask

  task automatic send_record(logic [7:0] cnt, logic [15:0] addr, logic [7:0] kind,
                             logic [15:0] ext, flaw_e flaw);
    logic [7:0]  bytes_q[$];
    logic [7:0]  line_q[$];
    logic [7:0]  sum;
    int unsigned k, n;
    bit          fix;
    bytes_q = {cnt, addr[15:8], addr[7:0], kind};
    for (int i = 0; i < cnt; i++) begin
      if ((kind == REC_EXT_SEG || kind == REC_EXT_LIN) && i < 2)
        bytes_q.push_back(i == 0 ? ext[15:8] : ext[7:0]);
      else
        bytes_q.push_back(rand_data());
    end
    if ((kind == REC_EXT_SEG || kind == REC_EXT_LIN) && cnt >= 2 && $urandom_range(0, 1))
      k = 4 + $urandom_range(0, 1);
    else
      k = $urandom_range(0, bytes_q.size() - 1);
    // a fixed-up bad digit leaves its byte out of the checksum, so the checksum stays good
    fix = (flaw == FL_DIGIT) && $urandom_range(0, 1);
    sum = 8'h00;
    for (int j = 0; j < bytes_q.size(); j++)
      if (!(fix && j == k)) sum = sum + bytes_q[j];
    sum = 8'h00 - sum;
    if (flaw == FL_SUM) sum = sum + 8'($urandom_range(1, 255));
    bytes_q.push_back(sum);

    line_q.push_back(CHAR_COLON);
    foreach (bytes_q[j]) begin
      line_q.push_back(hex_char(bytes_q[j][7:4]));
      line_q.push_back(hex_char(bytes_q[j][3:0]));
    end

    case (flaw)
      FL_START: begin
        line_q[0] = 8'($urandom_range(0, 255));
        if (line_q[0] == CHAR_COLON) line_q[0] = 8'h3B;
      end
      FL_SHORT: begin
        n = $urandom_range(1, 3);
        repeat (n) if (line_q.size() > 1) void'(line_q.pop_back());
      end
      FL_LONG: begin
        n = $urandom_range(1, 3);
        repeat (n) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      FL_DIGIT: line_q[1 + 2 * k + $urandom_range(0, 1)] = NON_HEX[$urandom_range(0, 9)];
      default: ;
    endcase

    if (flaw == FL_CUT) begin
      // abandon the line partway, then restart the file
      n = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > n) void'(line_q.pop_back());
      send_line(line_q, 1'b0);
      send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      send_line(line_q, 1'b1);
    end
  endtask

  task automatic send_random_line();
    int unsigned r;
    logic [7:0]  kind, cnt;
    logic [15:0] addr, ext;
    flaw_e       flaw;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6))
        send_item($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) == 0);
      return;
    end
    if (r < 12) begin
      send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 50) kind = REC_DATA;
    else if (r < 60) kind = REC_EXT_LIN;
    else if (r < 70) kind = REC_EXT_SEG;
    else if (r < 75) kind = REC_EOF;
    else if (r < 80) kind = REC_START_SEG;
    else if (r < 85) kind = REC_START_LIN;
    else kind = 8'($urandom_range(6, 255));
    r = $urandom_range(0, 99);
    if (kind == REC_DATA)
      cnt = (r < 85) ? 8'($urandom_range(0, 8)) : (r < 97) ? 8'($urandom_range(9, 32)) : 8'hFF;
    else if (kind == REC_EXT_LIN || kind == REC_EXT_SEG)
      cnt = (r < 80) ? 8'd2 : 8'($urandom_range(0, 4));
    else
      cnt = (r < 70) ? 8'd0 : 8'($urandom_range(0, 4));
    r = $urandom_range(0, 9);
    addr = (r == 0) ? 16'hFFFF - 16'($urandom_range(0, 8)) : 16'($urandom_range(0, 16'hFFFF));
    r = $urandom_range(0, 9);
    ext = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF));
    r = $urandom_range(0, 99);
    if (r < 62) flaw = FL_NONE;
    else if (r < 67) flaw = FL_START;
    else if (r < 74) flaw = FL_SHORT;
    else if (r < 80) flaw = FL_LONG;
    else if (r < 86) flaw = FL_SUM;
    else if (r < 95) flaw = FL_DIGIT;
    else flaw = FL_CUT;
    send_record(cnt, addr, kind, ext, flaw);
  endtask

  // Stop offering, wait until every outstanding result has transferred, then
  // let the pipeline settle.
  task automatic drain();
    draining = 1'b1;
    @(negedge clk_i);
    push <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    draining = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // result side: pop with random gaps, one long hold-off once the run is going
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          held;
    result_t     got;
    taken = 0;
    held  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && taken >= 120 && !draining) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      gap = rx_steady ? 0 : pick_gap();
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.kind         = res_kind_e'(result_kind_o);
      got.byte_address = byte_address_o;
      got.data_byte    = data_byte_o;
      got.line_number  = line_number_o;
      got.status       = status_e'(line_status_o);
      got.range_low    = range_low_o;
      got.range_high   = range_high_o;
      got.record_kind  = record_kind_o;
      board.match_result(got);
      taken++;
      if (taken % 50 == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    logic [7:0]  long_q[$];
    logic [31:0] lo_val, hi_val;
    int unsigned phase_start;
    board       = new();
    draining    = 1'b0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    items_sent  = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_MIN_ADDR;
    cfg_wdata_i = '0;
    push        = 1'b0;
    req_type_i  = 1'b0;
    char_code_i = '0;
    line_end_i  = 1'b0;
    pop         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: new file, bad start, bare colon, end-of-file record, data at top of bank
    send_item(1'b1, 8'hFF, 1'b1);
    send_text("X");
    send_text(":");
    send_text(":00000001FF");
    send_text(":01FFFF00FF02");

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin lo_val = '0; hi_val = '1; end
        1: begin lo_val = '1; hi_val = '0; end
        2: begin lo_val = $urandom(); hi_val = $urandom(); end
        3: begin
          lo_val = board.base_addr + $urandom_range(0, 16'hFFFF);
          hi_val = lo_val + $urandom_range(0, 12'h200);
        end
        4: begin lo_val = '0; hi_val = board.base_addr + $urandom_range(0, 17'h1FFFF); end
        default: begin lo_val = board.base_addr + $urandom_range(0, 16'hFFFF); hi_val = '1; end
      endcase
      write_reg(CFG_MIN_ADDR, lo_val);
      write_reg(CFG_MAX_ADDR, hi_val);

      if (ph == 2) begin
        // overlong data record: full 255 bytes, position saturates, length mismatch
        long_q = {CHAR_COLON, 8'h46, 8'h46, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30};
        while (long_q.size() < 1030) long_q.push_back(hex_char(4'($urandom_range(0, 15))));
        send_line(long_q, 1'b1);
      end

      phase_start = items_sent;
      while (items_sent - phase_start < 125) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        send_random_line();
      end
    end

    tx_steady = 1'b0;
    drain();
    if (board.errors == 0)
      $display("** hex_record_stream_parser_top: PASSED **");
    else
      $display("** hex_record_stream_parser_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
